// File: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tvob_pkg.sv
// types, codes and constant tables of the three voice oscillator bank
package tvob_pkg;

  localparam int VOICE_COUNT = 3;
  localparam int VOICE_W     = $clog2(VOICE_COUNT);
  localparam int REG_COUNT   = 25;
  localparam int ROW_BYTES   = 5;
  localparam int ROW_STRIDE  = 7;
  localparam int LFSR_W      = 23;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // byte offsets inside a voice row
  localparam logic [2:0] OFS_FREQ_LO = 3'd0;
  localparam logic [2:0] OFS_FREQ_HI = 3'd1;
  localparam logic [2:0] OFS_PW_LO   = 3'd2;
  localparam logic [2:0] OFS_PW_HI   = 3'd3;
  localparam logic [2:0] OFS_CTRL    = 3'd4;

  // control byte bits
  localparam int CTRL_NOISE = 7;
  localparam int CTRL_PULSE = 6;
  localparam int CTRL_SAW   = 5;
  localparam int CTRL_TRI   = 4;
  localparam int CTRL_TEST  = 3;
  localparam int CTRL_RING  = 2;
  localparam int CTRL_SYNC  = 1;

  localparam logic [15:0] CLOCK_RATIO_RESET = 16'd5255;

  localparam logic [LFSR_W-1:0] NOISE_SEED [VOICE_COUNT] = '{
    23'h7ffff8, 23'h6d2b79, 23'h5a1f33
  };

  // reciprocal of three for the three-waveform average
  localparam logic [17:0] RECIP3      = 18'd174763;
  localparam int          RECIP3_SH   = 19;
  localparam logic [18:0] DIV3_OFFSET = 19'd98304;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_UPD,
    S_SCALE,
    S_DIV,
    S_NEXT,
    S_OUT
  } tvob_state_t;

  typedef logic [15:0] noise_lut_t [256];

  // noise byte to sample level, rounded half up
  function automatic noise_lut_t build_noise_lut();
    noise_lut_t lut;
    int n;
    int q;
    for (int i = 0; i < 256; i++) begin
      n = (2 * i - 255) * 32767 + 127;
      if (n >= 0) q = n / 255;
      else q = -((-n + 254) / 255);
      lut[i] = 16'(q);
    end
    return lut;
  endfunction

  localparam noise_lut_t NOISE_LUT = build_noise_lut();

endpackage

// File: src/three_voice_oscillator_bank_top.sv
// Operation: a register write item is stored as it is accepted; a tick item steps each
// voice in turn through one shared read-modify-write path over the voice state memory,
// in states READ, MUL, UPD, SCALE, DIV and NEXT (test mode goes from MUL to NEXT,
// noise or no waveform from UPD to NEXT), then loads its result in S_OUT. One register
// write per cycle while idle; no item is taken while a tick runs or its result waits.
// Reset: synchronous active low; per-entry valid bits make both memories read as
// their reset values at once, so no clearing pass is needed.
`include "assert_macros.svh"

module three_voice_oscillator_bank_top
  import tvob_pkg::*;
#(
  parameter int PHASE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address [15:0], data [23:16]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // voice2_sample, voice1_sample, voice0_sample
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int PB  = PHASE_BITS;
  localparam int STW = 2 * PB + LFSR_W;
  localparam int XW  = PB + 18;
  localparam logic signed [PB+1:0] HALF_S = (PB+2)'(1) <<< (PB - 1);

  tvob_state_t state_r, state_nxt;
  logic [VOICE_W-1:0] voice_r;
  logic [VOICE_W-1:0] pv;
  logic [15:0] clock_ratio_r;

  // memories: voice registers and voice oscillator state
  logic [ROW_BYTES-1:0][7:0] reg_mem [VOICE_COUNT];
  logic [ROW_BYTES-1:0][7:0] reg_q;
  logic [ROW_BYTES-1:0]      reg_vld_r [VOICE_COUNT];
  logic [ROW_BYTES-1:0]      reg_vld_q;
  logic [STW-1:0]            st_mem [VOICE_COUNT];
  logic [STW-1:0]            st_q;
  logic [VOICE_COUNT-1:0]    st_vld_r;
  logic                      st_vld_q;

  logic [VOICE_COUNT-1:0] wrapped_r;
  logic [VOICE_COUNT-1:0] phase_hi_r;

  logic [31:0]             prod_r;
  logic signed [PB+1:0]    sum_r;
  logic [1:0]              count_r;
  logic signed [18:0]      y_r;
  logic [15:0]             samp_r [VOICE_COUNT];
  logic                    out_tvalid_r;
  logic [47:0]             out_tdata_r;

  // handshake and write decode
  logic       in_acc;
  logic       wr_acc;
  logic [4:0] idx;
  logic [1:0] row;
  logic [2:0] off;
  logic       reg_we;
  logic       test_we;
  logic       out_load;
  logic       st_we_tick;

  assign in_acc = in_tvalid && in_tready;
  assign wr_acc = in_acc && (in_tuser == OP_WRITE);
  assign idx    = in_tdata[4:0];

  // split the register index into voice row and byte offset
  always_comb begin
    if (idx < 5'd7) begin
      row = 2'd0;
      off = idx[2:0];
    end else if (idx < 5'd14) begin
      row = 2'd1;
      off = 3'(idx - 5'd7);
    end else if (idx < 5'd21) begin
      row = 2'd2;
      off = 3'(idx - 5'd14);
    end else begin
      row = 2'd3;
      off = 3'(idx - 5'd21);
    end
  end

  assign reg_we  = wr_acc && (row < 2'(VOICE_COUNT)) && (off < 3'(ROW_BYTES));
  assign test_we = reg_we && (off == OFS_CTRL) && in_tdata[16 + CTRL_TEST];

  // current voice fields, unwritten entries read as reset values
  logic [7:0] rb [ROW_BYTES];
  always_comb begin
    for (int k = 0; k < ROW_BYTES; k++) begin
      rb[k] = reg_vld_q[k] ? reg_q[k] : 8'd0;
    end
  end

  logic [15:0]       freq;
  logic [11:0]       pw;
  logic [7:0]        ctrl;
  logic [PB-1:0]     cur_phase;
  logic [PB-1:0]     cur_np;
  logic [LFSR_W-1:0] cur_s;

  assign freq = {rb[OFS_FREQ_HI], rb[OFS_FREQ_LO]};
  assign pw   = {rb[OFS_PW_HI][3:0], rb[OFS_PW_LO]};
  assign ctrl = rb[OFS_CTRL];
  assign cur_phase = st_vld_q ? st_q[STW-1 -: PB] : '0;
  assign cur_np    = st_vld_q ? st_q[LFSR_W +: PB] : '0;
  assign cur_s     = st_vld_q ? st_q[LFSR_W-1:0] : NOISE_SEED[voice_r];
  assign pv = (voice_r == '0) ? VOICE_W'(VOICE_COUNT - 1) : voice_r - 1'b1;

  // phase, sync, noise and waveform sum of the current voice
  logic [PB-1:0]        step;
  logic [PB:0]          ph_sum;
  logic [PB:0]          np_sum;
  logic [PB-1:0]        ph_new;
  logic                 wrap_new;
  logic [LFSR_W-1:0]    s_new;
  logic                 fb;
  logic [7:0]           noise_o;
  logic signed [PB+1:0] ph_s;
  logic signed [PB+1:0] tri_v;
  logic signed [PB+1:0] sum_c;
  logic [1:0]           count_c;
  logic [STW-1:0]       st_wdata_tick;
  logic                 sync_hit;

  always_comb begin
    step     = prod_r[31 -: PB];
    ph_sum   = {1'b0, cur_phase} + {1'b0, step};
    np_sum   = {1'b0, cur_np} + {1'b0, step};
    sync_hit = ctrl[CTRL_SYNC] && wrapped_r[pv];
    wrap_new = ph_sum[PB] || sync_hit;
    ph_new   = sync_hit ? '0 : ph_sum[PB-1:0];
    // at most one lfsr shift per tick, a step stays below one full phase period
    fb    = cur_s[22] ^ cur_s[17];
    s_new = cur_s;
    if (np_sum[PB]) begin
      s_new = {cur_s[LFSR_W-2:0], fb};
      if (s_new == '0) s_new = NOISE_SEED[voice_r];
    end
    noise_o = {s_new[20], s_new[18], s_new[14], s_new[11],
               s_new[9], s_new[5], s_new[2], s_new[0]};
    if (ctrl[CTRL_NOISE]) begin
      st_wdata_tick = {ph_new, np_sum[PB-1:0], s_new};
    end else begin
      st_wdata_tick = {ph_new, cur_np, cur_s};
    end
    ph_s    = $signed({2'b00, ph_new});
    sum_c   = '0;
    count_c = 2'd0;
    if (ctrl[CTRL_PULSE] && (pw != 12'd0)) begin
      if (ph_new < {pw, {(PB-12){1'b0}}}) sum_c = sum_c + HALF_S;
      else sum_c = sum_c - HALF_S;
      count_c = count_c + 2'd1;
    end
    if (ctrl[CTRL_SAW]) begin
      sum_c   = sum_c + (ph_s - HALF_S);
      count_c = count_c + 2'd1;
    end
    if (!ph_new[PB-1]) tri_v = (ph_s <<< 1) - HALF_S;
    else tri_v = (HALF_S + (HALF_S <<< 1)) - (ph_s <<< 1);
    if (ctrl[CTRL_RING] && phase_hi_r[pv]) tri_v = -tri_v;
    if (ctrl[CTRL_TRI]) begin
      sum_c   = sum_c + tri_v;
      count_c = count_c + 2'd1;
    end
  end

  // scale the sum by 32767 with rounding bias, then take the power of two part
  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] x_bias;
  logic signed [XW-1:0] x_c;
  always_comb begin
    x_ext = XW'(sum_r);
    case (count_r)
      2'd1:    x_bias = XW'(1) <<< (PB - 2);
      2'd2:    x_bias = XW'(1) <<< (PB - 1);
      default: x_bias = XW'(3) <<< (PB - 2);
    endcase
    x_c = (x_ext <<< 15) - x_ext + x_bias;
  end

  // for three waveforms divide by three through a reciprocal, then saturate
  logic [17:0]        y_off;
  logic [35:0]        q3_prod;
  logic signed [18:0] q_c;
  logic [15:0]        q_sat;
  always_comb begin
    y_off   = 18'(y_r + $signed(DIV3_OFFSET));
    q3_prod = y_off * RECIP3;
    if (count_r == 2'd3) q_c = $signed({2'b00, q3_prod[35:RECIP3_SH]}) - 19'sd32768;
    else q_c = y_r;
    if (q_c > 19'sd32767) q_sat = 16'h7fff;
    else if (q_c < -19'sd32768) q_sat = 16'h8000;
    else q_sat = q_c[15:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && (in_tuser == OP_TICK)) state_nxt = S_READ;
      S_READ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = ctrl[CTRL_TEST] ? S_NEXT : S_UPD;
      S_UPD: begin
        if (ctrl[CTRL_NOISE] || (count_c == 2'd0)) state_nxt = S_NEXT;
        else state_nxt = S_SCALE;
      end
      S_SCALE: state_nxt = S_DIV;
      S_DIV:   state_nxt = S_NEXT;
      S_NEXT:  state_nxt = (voice_r == VOICE_W'(VOICE_COUNT - 1)) ? S_OUT : S_READ;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    st_we_tick = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_UPD:   st_we_tick = 1'b1;
      S_OUT:   out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      voice_r       <= '0;
      clock_ratio_r <= CLOCK_RATIO_RESET;
      st_vld_r      <= '0;
      wrapped_r     <= '0;
      phase_hi_r    <= '0;
      out_tvalid_r  <= 1'b0;
      for (int v = 0; v < VOICE_COUNT; v++) reg_vld_r[v] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) clock_ratio_r <= cfg_data;
      if (state_r == S_IDLE) voice_r <= '0;
      else if ((state_r == S_NEXT) && (voice_r != VOICE_W'(VOICE_COUNT - 1)))
        voice_r <= voice_r + 1'b1;
      if (reg_we) reg_vld_r[row[VOICE_W-1:0]][off] <= 1'b1;
      if (test_we) begin
        st_vld_r[row[VOICE_W-1:0]]   <= 1'b1;
        phase_hi_r[row[VOICE_W-1:0]] <= 1'b0;
      end
      if (st_we_tick) begin
        st_vld_r[voice_r]   <= 1'b1;
        wrapped_r[voice_r]  <= wrap_new;
        phase_hi_r[voice_r] <= ph_new[PB-1];
      end
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // memories, read data registered
  always_ff @(posedge clk) begin
    if (reg_we) reg_mem[row[VOICE_W-1:0]][off] <= in_tdata[23:16];
    reg_q     <= reg_mem[voice_r];
    reg_vld_q <= reg_vld_r[voice_r];
    if (test_we) begin
      st_mem[row[VOICE_W-1:0]] <= {{PB{1'b0}}, {PB{1'b0}}, NOISE_SEED[row[VOICE_W-1:0]]};
    end else if (st_we_tick) begin
      st_mem[voice_r] <= st_wdata_tick;
    end
    st_q     <= st_mem[voice_r];
    st_vld_q <= st_vld_r[voice_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_MUL: begin
        prod_r <= freq * clock_ratio_r;
        if (ctrl[CTRL_TEST]) samp_r[voice_r] <= 16'd0;
      end
      S_UPD: begin
        sum_r   <= sum_c;
        count_r <= count_c;
        if (ctrl[CTRL_NOISE]) samp_r[voice_r] <= NOISE_LUT[noise_o];
        else if (count_c == 2'd0) samp_r[voice_r] <= 16'd0;
      end
      S_SCALE: begin
        if (count_r == 2'd2) y_r <= 19'(x_c >>> PB);
        else y_r <= 19'(x_c >>> (PB - 1));
      end
      S_DIV: samp_r[voice_r] <= q_sat;
      default: ;
    endcase
    if (out_load) out_tdata_r <= {samp_r[2], samp_r[1], samp_r[0]};
  end

  `ASSERT_NEXT(a_tick_starts, in_acc && (in_tuser == OP_TICK), (state_r == S_READ) && (voice_r == '0), "tick did not start at voice 0")
  `ASSERT_NEXT(a_sync_zero, (state_r == S_UPD) && sync_hit, wrapped_r[voice_r] && !phase_hi_r[voice_r], "hard sync did not zero the phase")
  `ASSERT_NOW(a_no_write_busy, reg_we, state_r == S_IDLE, "register write taken while busy")
  `ASSERT_NEXT(a_result_shown, out_load, out_tvalid, "result not presented after load")

endmodule

// File: verif/three_voice_oscillator_bank_top_tb.sv
// self-checking testbench for the three voice oscillator bank
module three_voice_oscillator_bank_top_tb;
  import tvob_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PH_BITS = 24;
  localparam longint PH_ONE = 64'd1 << PH_BITS;
  localparam longint PH_HALF = 64'd1 << (PH_BITS - 1);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  // voice model and queue of expected sample triples
  class voice_predictor;
    logic [7:0] regs [REG_COUNT];
    longint phase [VOICE_COUNT];
    bit wrapped [VOICE_COUNT];
    longint noise_acc [VOICE_COUNT];
    logic [LFSR_W-1:0] lfsr [VOICE_COUNT];
    logic [15:0] ratio;
    logic [47:0] expected_samples [$];
    int mismatches;

    function new();
      for (int i = 0; i < REG_COUNT; i++) regs[i] = 8'h00;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        phase[v] = 0;
        wrapped[v] = 0;
        noise_acc[v] = 0;
        lfsr[v] = NOISE_SEED[v];
      end
      ratio = CLOCK_RATIO_RESET;
      mismatches = 0;
    endfunction

    // rounds half up, then saturates to 16 bits
    function logic [15:0] round_sat(longint num, longint den);
      longint n;
      longint q;
      n = num + den / 2;
      if (n >= 0) q = n / den;
      else q = -((-n + den - 1) / den);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function int prev_of(int v);
      return (v == 0) ? VOICE_COUNT - 1 : v - 1;
    endfunction

    function logic [15:0] run_voice(int v);
      logic [7:0] ctrl;
      longint freq;
      longint pw;
      longint step;
      longint nxt;
      longint p;
      longint total;
      longint sum;
      longint cnt;
      longint t;
      logic [LFSR_W-1:0] s;
      logic [7:0] o;
      ctrl = regs[v * ROW_STRIDE + OFS_CTRL];
      freq = {regs[v * ROW_STRIDE + OFS_FREQ_HI], regs[v * ROW_STRIDE + OFS_FREQ_LO]};
      pw = {regs[v * ROW_STRIDE + OFS_PW_HI][3:0], regs[v * ROW_STRIDE + OFS_PW_LO]};
      sum = 0;
      cnt = 0;
      if (ctrl[CTRL_TEST]) return 16'h0000;
      step = ((freq * longint'(ratio)) << (PH_BITS - 16)) >> 16;
      nxt = phase[v] + step;
      wrapped[v] = nxt >= PH_ONE;
      phase[v] = nxt & (PH_ONE - 1);
      // hard sync off the previous voice
      if (ctrl[CTRL_SYNC] && wrapped[prev_of(v)]) begin
        phase[v] = 0;
        wrapped[v] = 1;
      end
      if (ctrl[CTRL_NOISE]) begin
        total = noise_acc[v] + step;
        noise_acc[v] = total & (PH_ONE - 1);
        s = lfsr[v];
        for (longint k = total >> PH_BITS; k > 0; k--) begin
          s = {s[LFSR_W-2:0], s[22] ^ s[17]};
          if (s == '0) s = NOISE_SEED[v];
        end
        lfsr[v] = s;
        o = {s[20], s[18], s[14], s[11], s[9], s[5], s[2], s[0]};
        return round_sat((2 * longint'(o) - 255) * 32767, 255);
      end
      p = phase[v];
      if (ctrl[CTRL_PULSE] && pw != 0) begin
        sum += (p < (pw << (PH_BITS - 12))) ? PH_HALF : -PH_HALF;
        cnt++;
      end
      if (ctrl[CTRL_SAW]) begin
        sum += p - PH_HALF;
        cnt++;
      end
      if (ctrl[CTRL_TRI]) begin
        if (p < PH_HALF) t = 2 * p - PH_HALF;
        else t = 3 * PH_HALF - 2 * p;
        // ring modulation flips the triangle
        if (ctrl[CTRL_RING] && phase[prev_of(v)] >= PH_HALF) t = -t;
        sum += t;
        cnt++;
      end
      if (cnt == 0) return 16'h0000;
      return round_sat(sum * 32767, cnt * PH_HALF);
    endfunction

    // apply one accepted input item
    function void note_item(logic op, logic [15:0] addr, logic [7:0] data);
      int idx;
      logic [47:0] trio;
      if (op == OP_TICK) begin
        for (int v = 0; v < VOICE_COUNT; v++) trio[16*v +: 16] = run_voice(v);
        expected_samples = {expected_samples, trio};
        return;
      end
      if (addr >= 16'hd400 && addr <= 16'hd418) idx = addr - 16'hd400;
      else if (addr <= 16'h0018) idx = addr;
      else idx = addr[4:0];
      if (idx >= REG_COUNT) return;
      regs[idx] = data;
      // test bit resets the voice
      if ((idx % ROW_STRIDE) == OFS_CTRL && data[CTRL_TEST]) begin
        phase[idx / ROW_STRIDE] = 0;
        noise_acc[idx / ROW_STRIDE] = 0;
        lfsr[idx / ROW_STRIDE] = NOISE_SEED[idx / ROW_STRIDE];
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    // compare one result item with the oldest expectation
    task check_samples(logic [47:0] got);
      logic [47:0] want;
      if (expected_samples.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_samples.pop_front();
      for (int v = 0; v < VOICE_COUNT; v++)
        if (got[16*v +: 16] !== want[16*v +: 16])
          report($sformatf("voice%0d got %h want %h", v, got[16*v +: 16], want[16*v +: 16]));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  voice_predictor model = new();
  int cycles = 0;
  int burst_left = 0;
  bit hold_off = 0;
  int ready_mode = 0;

  three_voice_oscillator_bank_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // input and result monitors
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) model.note_item(in_tuser, in_tdata[15:0], in_tdata[23:16]);
    if (rst_n && out_tvalid && out_tready) model.check_samples(out_tdata);
  end

  // receiver stall pattern, with its mode redrawn at random
  always @(posedge clk) begin
    if (cycles % 64 == 0) ready_mode <= $urandom_range(0, 3);
    if (hold_off) out_tready <= 1'b0;
    else case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= ($urandom_range(0, 7) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(logic op, logic [15:0] addr, logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {data, addr};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic write_reg(int idx, logic [7:0] data);
    logic [15:0] a;
    // pick one of the address forms that map to the index
    case ($urandom_range(0, 2))
      0: a = 16'(16'hd400 + idx);
      1: a = 16'(idx);
      default: a = {11'($urandom_range(0, 2047)), 5'(idx)} | 16'h0020;
    endcase
    if (a >= 16'hd400 && a <= 16'hd418 && a - 16'hd400 != idx) a = 16'(16'hd400 + idx);
    send_item(OP_WRITE, a, data);
  endtask

  task automatic tick();
    send_item(OP_TICK, 16'($urandom), 8'($urandom));
  endtask

  // wait for the block to go idle, then write the clock ratio
  task automatic set_ratio(logic [15:0] r);
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (model.expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    model.ratio = r;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(int n);
    logic [7:0] ctrl;
    int idx;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: tick();
        3: send_item(OP_WRITE, 16'($urandom), 8'($urandom));
        4, 5: begin
          idx = $urandom_range(0, VOICE_COUNT - 1) * ROW_STRIDE + OFS_CTRL;
          ctrl = 8'($urandom);
          if ($urandom_range(0, 7) != 0) ctrl[CTRL_TEST] = 1'b0;
          write_reg(idx, ctrl);
        end
        default: write_reg($urandom_range(0, REG_COUNT - 1), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: address forms, ignored indices, waveforms and special cases
    write_reg(0, 8'hff);
    send_item(OP_WRITE, 16'hd401, 8'hff);
    send_item(OP_WRITE, 16'hd404, 8'h20);
    tick();
    send_item(OP_WRITE, 16'h0019, 8'hff);
    send_item(OP_WRITE, 16'hffff, 8'hff);
    send_item(OP_WRITE, 16'hd419, 8'hff);
    send_item(OP_WRITE, 16'h0018, 8'h00);
    send_item(OP_WRITE, 16'h0007, 8'h34);
    send_item(OP_WRITE, 16'h0008, 8'h12);
    send_item(OP_WRITE, 16'h000b, 8'h16);
    send_item(OP_WRITE, 16'hd40e, 8'h00);
    send_item(OP_WRITE, 16'hd40f, 8'hff);
    send_item(OP_WRITE, 16'hd412, 8'hf2);
    tick();
    tick();
    send_item(OP_WRITE, 16'h0024, 8'h40);
    tick();
    send_item(OP_WRITE, 16'h0002, 8'h00);
    send_item(OP_WRITE, 16'h0003, 8'h08);
    tick();
    send_item(OP_WRITE, 16'h0004, 8'h88);
    tick();
    send_item(OP_WRITE, 16'h0004, 8'h80);
    tick();
    send_item(OP_WRITE, 16'h0004, 8'h00);
    tick();

    // random phases over several clock ratios, one with a long receiver stall
    random_items(250);
    set_ratio(16'd1);
    random_items(200);
    set_ratio(16'hffff);
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
    join_none
    random_items(300);
    set_ratio(16'($urandom_range(1, 65535)));
    random_items(250);
    set_ratio(CLOCK_RATIO_RESET);
    random_items(250);

    in_tvalid <= 1'b0;
    while (model.expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/tvob_pkg.sv
src/three_voice_oscillator_bank_top.sv
verif/three_voice_oscillator_bank_top_tb.sv
